// ===== src/trinorm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package trinorm_pkg;

   localparam int COORD_BITS       = 16;
   localparam int NORMAL_FRAC_BITS = 14;

   // derived datapath widths
   localparam int DIFF_BITS   = COORD_BITS + 1;
   localparam int PROD_BITS   = 2 * DIFF_BITS;
   localparam int CROSS_BITS  = PROD_BITS + 1;
   localparam int MAG_BITS    = PROD_BITS;
   localparam int LO_BITS     = MAG_BITS / 2;
   localparam int HI_BITS     = MAG_BITS - LO_BITS;
   localparam int SQ_BITS     = 2 * MAG_BITS;
   localparam int SUM_BITS    = SQ_BITS + 2;
   localparam int REM_BITS    = SUM_BITS + 1;
   localparam int QUOT_BITS   = 2 * NORMAL_FRAC_BITS + 1;
   localparam int ROOT_BITS   = NORMAL_FRAC_BITS + 1;
   localparam int NORMAL_BITS = NORMAL_FRAC_BITS + 2;

   // pipeline depths
   localparam int FRONT_STAGES = 7;
   localparam int DIV_STAGES   = QUOT_BITS;
   localparam int SQRT_STAGES  = ROOT_BITS;
   localparam int MID_STAGES   = DIV_STAGES + SQRT_STAGES;
   localparam int LATENCY      = FRONT_STAGES + MID_STAGES + 1;

   typedef logic signed [COORD_BITS-1:0]  coord_type;
   typedef logic signed [NORMAL_BITS-1:0] normal_type;

   typedef enum logic [1:0] {
      ST_VALID      = 2'd0,
      ST_COINCIDENT = 2'd1,
      ST_COLLINEAR  = 2'd2
   } status_type;

   typedef struct packed {
      coord_type v0_x;
      coord_type v0_y;
      coord_type v0_z;
      coord_type v1_x;
      coord_type v1_y;
      coord_type v1_z;
      coord_type v2_x;
      coord_type v2_y;
      coord_type v2_z;
   } req_type;

   typedef struct packed {
      normal_type normal_x;
      normal_type normal_y;
      normal_type normal_z;
      status_type status;
   } rsp_type;

   // sideband that rides along with the arithmetic
   typedef struct packed {
      status_type status;
      logic [2:0] neg;
   } tag_type;

endpackage
`default_nettype wire

// ===== src/triangle_unit_normal_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Unit face normal of a triangle. A beat on req_item carries three vertices in signed
// Q8.8; it is taken on a clock edge with start high and busy low. The block forms
// N = (A-B) x (B-C) and returns N/|N| as signed Q1.14 components truncated toward zero.
// Coincident vertices give a zero vector with status coincident; a zero cross product
// gives a zero vector with status collinear. The pipeline takes one triangle every clock
// while busy is low and returns each result through 7 front stages, 29 restoring divider
// stages, 15 square root stages and 1 output register, flagged by a one-cycle rsp_valid
// strobe. Results cannot be held off, so the receiver must take every strobe. busy is
// high only during reset and the cycle after it.
module triangle_unit_normal_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  trinorm_pkg::req_type  req_item,
   output logic                  busy,
   output logic                  rsp_valid,
   output trinorm_pkg::rsp_type  rsp_item
);
   import trinorm_pkg::*;

   logic                          accept;
   logic                          busy_ff;

   // front end: edges, cross product, squares and squared length
   logic                          front_valid;
   tag_type                       front_tag;
   logic [SUM_BITS-1:0]           front_sum;
   logic [2:0][SQ_BITS-1:0]       front_sq;

   // per component quotient and root
   logic [QUOT_BITS-1:0]          quot [3];
   logic [ROOT_BITS-1:0]          root [3];

   // sideband delay matching the divider and root pipelines
   logic [MID_STAGES:1]           mid_valid_ff, mid_valid_in;
   tag_type                       mid_tag_ff [1:MID_STAGES];

   // output register
   normal_type                    comp [3];
   rsp_type                       rsp_item_ff, rsp_item_in;
   logic                          rsp_valid_ff;

   assign accept = start && !busy_ff;

   trinorm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_item   (req_item),
      .out_valid (front_valid),
      .out_tag   (front_tag),
      .out_sum   (front_sum),
      .out_sq    (front_sq)
   );

   // |n_i|^2 * 2^(2F) / S, then its square root gives the truncated magnitude
   for (genvar c = 0; c < 3; c++) begin : g_comp
      trinorm_div u_div (
         .clock    (clock),
         .in_num   (front_sq[c]),
         .in_den   (front_sum),
         .out_quot (quot[c])
      );

      trinorm_isqrt u_isqrt (
         .clock    (clock),
         .in_val   (quot[c]),
         .out_root (root[c])
      );
   end

   assign mid_valid_in = {mid_valid_ff[MID_STAGES-1:1], front_valid};

   always_ff @(posedge clock) begin
      mid_tag_ff[1] <= front_tag;
      for (int i = 2; i <= MID_STAGES; i++) begin
         mid_tag_ff[i] <= mid_tag_ff[i-1];
      end
   end

   // apply sign, and force zero on degenerate triangles
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (mid_tag_ff[MID_STAGES].status != ST_VALID) begin
            comp[i] = '0;
         end else if (mid_tag_ff[MID_STAGES].neg[i]) begin
            comp[i] = NORMAL_BITS'(0) - NORMAL_BITS'(root[i]);
         end else begin
            comp[i] = NORMAL_BITS'(root[i]);
         end
      end
      rsp_item_in.normal_x = comp[0];
      rsp_item_in.normal_y = comp[1];
      rsp_item_in.normal_z = comp[2];
      rsp_item_in.status   = mid_tag_ff[MID_STAGES].status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         mid_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         mid_valid_ff <= mid_valid_in;
         rsp_valid_ff <= mid_valid_ff[MID_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // every result beat goes back to a beat taken a fixed latency earlier
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result beat without matching request");

   // a proper normal is never the zero vector
   a_nonzero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status == ST_VALID) |->
      (rsp_item.normal_x != '0 || rsp_item.normal_y != '0 || rsp_item.normal_z != '0))
      else $error("zero normal with valid status");

   // degenerate triangles give the zero vector
   a_degenerate : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status != ST_VALID) |->
      (rsp_item.normal_x == '0 && rsp_item.normal_y == '0 && rsp_item.normal_z == '0))
      else $error("nonzero normal on degenerate triangle");

   // busy only follows reset
   a_busy : assert property (@(posedge clock) disable iff (reset)
      busy |-> $past(reset))
      else $error("busy outside reset recovery");

endmodule
`default_nettype wire

// ===== src/trinorm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module trinorm_front (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       in_valid,
   input  trinorm_pkg::req_type                       in_item,
   output logic                                       out_valid,
   output trinorm_pkg::tag_type                       out_tag,
   output logic [trinorm_pkg::SUM_BITS-1:0]           out_sum,
   output logic [2:0][trinorm_pkg::SQ_BITS-1:0]       out_sq
);
   import trinorm_pkg::*;

   logic [FRONT_STAGES:1] valid_ff, valid_in;

   coord_type va [3];
   coord_type vb [3];
   coord_type vc [3];

   logic signed [DIFF_BITS-1:0]  s1_dx_ff [3], s1_dx_in [3];
   logic signed [DIFF_BITS-1:0]  s1_dy_ff [3], s1_dy_in [3];
   logic                         s1_coinc_ff, s1_coinc_in;
   logic signed [PROD_BITS-1:0]  s2_prod_ff [6], s2_prod_in [6];
   logic                         s2_coinc_ff;
   logic signed [CROSS_BITS-1:0] s3_n_ff [3], s3_n_in [3];
   logic                         s3_coinc_ff;
   logic [MAG_BITS-1:0]          s4_mag_ff [3], s4_mag_in [3];
   tag_type                      s4_tag_ff, s4_tag_in;
   logic [2*HI_BITS-1:0]         s5_hh_ff [3], s5_hh_in [3];
   logic [HI_BITS+LO_BITS-1:0]   s5_hl_ff [3], s5_hl_in [3];
   logic [2*LO_BITS-1:0]         s5_ll_ff [3], s5_ll_in [3];
   tag_type                      s5_tag_ff;
   logic [SQ_BITS-1:0]           s6_sq_ff [3], s6_sq_in [3];
   tag_type                      s6_tag_ff;
   logic [SQ_BITS-1:0]           s7_sq_ff [3];
   logic [SUM_BITS-1:0]          s7_sum_ff, s7_sum_in;
   tag_type                      s7_tag_ff;

   assign valid_in = {valid_ff[FRONT_STAGES-1:1], in_valid};

   // stage 1: edge vectors and coincidence
   always_comb begin
      va[0] = in_item.v0_x; va[1] = in_item.v0_y; va[2] = in_item.v0_z;
      vb[0] = in_item.v1_x; vb[1] = in_item.v1_y; vb[2] = in_item.v1_z;
      vc[0] = in_item.v2_x; vc[1] = in_item.v2_y; vc[2] = in_item.v2_z;
      for (int i = 0; i < 3; i++) begin
         s1_dx_in[i] = {va[i][COORD_BITS-1], va[i]} - {vb[i][COORD_BITS-1], vb[i]};
         s1_dy_in[i] = {vb[i][COORD_BITS-1], vb[i]} - {vc[i][COORD_BITS-1], vc[i]};
      end
      s1_coinc_in = (va[0] == vb[0] && va[1] == vb[1] && va[2] == vb[2]) ||
                    (va[0] == vc[0] && va[1] == vc[1] && va[2] == vc[2]) ||
                    (vb[0] == vc[0] && vb[1] == vc[1] && vb[2] == vc[2]);
   end

   // stage 2: cross product terms
   always_comb begin
      s2_prod_in[0] = s1_dx_ff[1] * s1_dy_ff[2];
      s2_prod_in[1] = s1_dx_ff[2] * s1_dy_ff[1];
      s2_prod_in[2] = s1_dx_ff[2] * s1_dy_ff[0];
      s2_prod_in[3] = s1_dx_ff[0] * s1_dy_ff[2];
      s2_prod_in[4] = s1_dx_ff[0] * s1_dy_ff[1];
      s2_prod_in[5] = s1_dx_ff[1] * s1_dy_ff[0];
   end

   // stage 3: cross product
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s3_n_in[i] = {s2_prod_ff[2*i][PROD_BITS-1], s2_prod_ff[2*i]}
                    - {s2_prod_ff[2*i+1][PROD_BITS-1], s2_prod_ff[2*i+1]};
      end
   end

   // stage 4: sign, magnitude, status
   always_comb begin
      logic [CROSS_BITS-1:0] abs_v;
      logic                  zero;
      abs_v = '0;
      for (int i = 0; i < 3; i++) begin
         s4_tag_in.neg[i] = s3_n_ff[i][CROSS_BITS-1];
         abs_v = s3_n_ff[i][CROSS_BITS-1] ? (~s3_n_ff[i] + 1'b1) : s3_n_ff[i];
         s4_mag_in[i] = abs_v[MAG_BITS-1:0];
      end
      zero = (s3_n_ff[0] == '0) && (s3_n_ff[1] == '0) && (s3_n_ff[2] == '0);
      priority if (s3_coinc_ff) begin
         s4_tag_in.status = ST_COINCIDENT;
      end else if (zero) begin
         s4_tag_in.status = ST_COLLINEAR;
      end else begin
         s4_tag_in.status = ST_VALID;
      end
   end

   // stage 5: split squares into partial products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s5_hh_in[i] = s4_mag_ff[i][MAG_BITS-1:LO_BITS] * s4_mag_ff[i][MAG_BITS-1:LO_BITS];
         s5_hl_in[i] = s4_mag_ff[i][MAG_BITS-1:LO_BITS] * s4_mag_ff[i][LO_BITS-1:0];
         s5_ll_in[i] = s4_mag_ff[i][LO_BITS-1:0] * s4_mag_ff[i][LO_BITS-1:0];
      end
   end

   // stage 6: recombine squares
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s6_sq_in[i] = (SQ_BITS'(s5_hh_ff[i]) << (2*LO_BITS))
                     + (SQ_BITS'(s5_hl_ff[i]) << (LO_BITS+1))
                     + SQ_BITS'(s5_ll_ff[i]);
      end
   end

   // stage 7: squared length
   assign s7_sum_in = SUM_BITS'(s6_sq_ff[0]) + SUM_BITS'(s6_sq_ff[1])
                    + SUM_BITS'(s6_sq_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_dx_ff    <= s1_dx_in;
      s1_dy_ff    <= s1_dy_in;
      s1_coinc_ff <= s1_coinc_in;
      s2_prod_ff  <= s2_prod_in;
      s2_coinc_ff <= s1_coinc_ff;
      s3_n_ff     <= s3_n_in;
      s3_coinc_ff <= s2_coinc_ff;
      s4_mag_ff   <= s4_mag_in;
      s4_tag_ff   <= s4_tag_in;
      s5_hh_ff    <= s5_hh_in;
      s5_hl_ff    <= s5_hl_in;
      s5_ll_ff    <= s5_ll_in;
      s5_tag_ff   <= s4_tag_ff;
      s6_sq_ff    <= s6_sq_in;
      s6_tag_ff   <= s5_tag_ff;
      s7_sq_ff    <= s6_sq_ff;
      s7_sum_ff   <= s7_sum_in;
      s7_tag_ff   <= s6_tag_ff;
   end

   assign out_valid = valid_ff[FRONT_STAGES];
   assign out_tag   = s7_tag_ff;
   assign out_sum   = s7_sum_ff;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         out_sq[i] = s7_sq_ff[i];
      end
   end

endmodule
`default_nettype wire

// ===== src/trinorm_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module trinorm_div (
   input  logic                               clock,
   input  logic [trinorm_pkg::SQ_BITS-1:0]    in_num,
   input  logic [trinorm_pkg::SUM_BITS-1:0]   in_den,
   output logic [trinorm_pkg::QUOT_BITS-1:0]  out_quot
);
   import trinorm_pkg::*;

   // restoring division of num * 2^(2F) by den, one quotient bit per stage
   logic [REM_BITS-1:0]  rem_ff  [1:DIV_STAGES-1];
   logic [SUM_BITS-1:0]  den_ff  [1:DIV_STAGES-1];
   logic [QUOT_BITS-1:0] quot_ff [1:DIV_STAGES];

   for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_step
      logic [REM_BITS-1:0]  trial;
      logic [REM_BITS-1:0]  diff_v;
      logic [SUM_BITS-1:0]  den_v;
      logic [QUOT_BITS-1:0] quot_v;
      logic                 take;

      if (k == 1) begin : g_first
         assign trial  = REM_BITS'(in_num);
         assign den_v  = in_den;
         assign quot_v = '0;
      end else begin : g_rest
         assign trial  = {rem_ff[k-1][REM_BITS-2:0], 1'b0};
         assign den_v  = den_ff[k-1];
         assign quot_v = quot_ff[k-1];
      end

      assign take   = trial >= {1'b0, den_v};
      assign diff_v = trial - {1'b0, den_v};

      always_ff @(posedge clock) begin
         quot_ff[k] <= {quot_v[QUOT_BITS-2:0], take};
      end

      // the last stage only needs its quotient bit
      if (k < DIV_STAGES) begin : g_den
         always_ff @(posedge clock) begin
            rem_ff[k] <= take ? diff_v : trial;
            den_ff[k] <= den_v;
         end
      end
   end

   assign out_quot = quot_ff[DIV_STAGES];

endmodule
`default_nettype wire

// ===== src/trinorm_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
module trinorm_isqrt (
   input  logic                               clock,
   input  logic [trinorm_pkg::QUOT_BITS-1:0]  in_val,
   output logic [trinorm_pkg::ROOT_BITS-1:0]  out_root
);
   import trinorm_pkg::*;

   // digit-by-digit integer square root, one result bit per stage
   logic [QUOT_BITS-1:0] num_ff [1:SQRT_STAGES-1];
   logic [QUOT_BITS-1:0] res_ff [1:SQRT_STAGES];

   for (genvar k = 1; k <= SQRT_STAGES; k++) begin : g_step
      localparam logic [QUOT_BITS-1:0] BIT = QUOT_BITS'(1) << (2 * (SQRT_STAGES - k));
      logic [QUOT_BITS-1:0] num_v;
      logic [QUOT_BITS-1:0] res_v;
      logic [QUOT_BITS-1:0] trial;
      logic                 take;

      if (k == 1) begin : g_first
         assign num_v = in_val;
         assign res_v = '0;
      end else begin : g_rest
         assign num_v = num_ff[k-1];
         assign res_v = res_ff[k-1];
      end

      assign trial = res_v + BIT;
      assign take  = num_v >= trial;

      always_ff @(posedge clock) begin
         res_ff[k] <= take ? ((res_v >> 1) + BIT) : (res_v >> 1);
      end

      if (k < SQRT_STAGES) begin : g_num
         always_ff @(posedge clock) begin
            num_ff[k] <= take ? (num_v - trial) : num_v;
         end
      end
   end

   assign out_root = res_ff[SQRT_STAGES][ROOT_BITS-1:0];

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
`default_nettype none
module testbench;
   import trinorm_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = LATENCY + 20;

   logic    clock;
   logic    reset;
   logic    start;
   req_type req_item;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_item;

   triangle_unit_normal_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_item  (req_item),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // normals still owed by the pipeline, oldest first
   rsp_type pending_normals[$];
   bit      failed;
   int      cycle_count;
   int      sender_idle_pct;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // exact truncated unit normal of (A-B) x (B-C), in Q1.14
   function automatic rsp_type predict_normal(req_type tri_in);
      longint      a[3], b[3], c[3], dx[3], dy[3], n[3];
      logic [127:0] sum_sq, mag, rhs, lhs, root, cand;
      rsp_type     res;
      normal_type  comp[3];
      a = '{tri_in.v0_x, tri_in.v0_y, tri_in.v0_z};
      b = '{tri_in.v1_x, tri_in.v1_y, tri_in.v1_z};
      c = '{tri_in.v2_x, tri_in.v2_y, tri_in.v2_z};
      res = '0;
      if (a == b || a == c || b == c) begin
         res.status = ST_COINCIDENT;
         return res;
      end
      for (int i = 0; i < 3; i++) begin
         dx[i] = a[i] - b[i];
         dy[i] = b[i] - c[i];
      end
      n[0] = dx[1] * dy[2] - dx[2] * dy[1];
      n[1] = dx[2] * dy[0] - dx[0] * dy[2];
      n[2] = dx[0] * dy[1] - dx[1] * dy[0];
      if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
         res.status = ST_COLLINEAR;
         return res;
      end
      sum_sq = '0;
      for (int i = 0; i < 3; i++) begin
         mag = (n[i] < 0) ? -n[i] : n[i];
         sum_sq += mag * mag;
      end
      for (int i = 0; i < 3; i++) begin
         mag = (n[i] < 0) ? -n[i] : n[i];
         rhs = (mag * mag) << (2 * NORMAL_FRAC_BITS);
         root = '0;
         // largest root with root^2 * |N|^2 <= N_i^2 * 2^(2F)
         for (int bit_pos = NORMAL_FRAC_BITS; bit_pos >= 0; bit_pos--) begin
            cand = root | (128'd1 << bit_pos);
            lhs = cand * cand * sum_sq;
            if (lhs <= rhs) root = cand;
         end
         comp[i] = (n[i] < 0) ? normal_type'(-root) : normal_type'(root);
      end
      res.normal_x = comp[0];
      res.normal_y = comp[1];
      res.normal_z = comp[2];
      res.status   = ST_VALID;
      return res;
   endfunction

   function automatic coord_type pick_coord(int span);
      case ($urandom_range(0, 5))
         0: return coord_type'($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
         1, 2: return coord_type'($urandom);
         default: return coord_type'($urandom_range(0, 2 * span) - span);
      endcase
   endfunction

   // mostly proper triangles, with coincident and collinear ones mixed in
   function automatic req_type make_triangle();
      req_type   t;
      coord_type p[9];
      int        span, k;
      span = $urandom_range(0, 3) == 0 ? 32767 : (1 << $urandom_range(1, 10));
      foreach (p[i]) p[i] = pick_coord(span);
      case ($urandom_range(0, 9))
         0: begin
            // two vertices share a point
            k = $urandom_range(0, 2);
            for (int i = 0; i < 3; i++)
               if (k == 0) p[3+i] = p[i];
               else if (k == 1) p[6+i] = p[i];
               else p[6+i] = p[3+i];
         end
         1: begin
            // third vertex on the line through the first two
            k = $urandom_range(0, 1) ? 2 : -1;
            for (int i = 0; i < 3; i++) begin
               p[i]   = coord_type'($urandom_range(0, 2000) - 1000);
               p[3+i] = coord_type'($urandom_range(0, 2000) - 1000);
               p[6+i] = p[3+i] + k * (p[3+i] - p[i]);
            end
         end
         2: begin
            // near-degenerate sliver, off the line by one lsb
            for (int i = 0; i < 3; i++) p[6+i] = p[3+i] + (p[3+i] - p[i]);
            p[6 + $urandom_range(0, 2)] += 1;
         end
         default: ;
      endcase
      t = {p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], p[8]};
      return t;
   endfunction

   // one beat: hold start until the block takes it, then maybe idle
   task automatic send_triangle(req_type t, bit has_typed, rsp_type typed_normal);
      start    <= 1'b1;
      req_item <= t;
      do @(posedge clock); while (busy);
      pending_normals.push_back(has_typed ? typed_normal : predict_normal(t));
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // result side: every strobe is a beat
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_normals.size() == 0) begin
            $error("unexpected normal beat %p", rsp_item);
            failed = 1'b1;
         end else begin
            rsp_type want;
            want = pending_normals.pop_front();
            if (rsp_item.normal_x !== want.normal_x) begin
               $error("normal_x expected %0d actual %0d", want.normal_x, rsp_item.normal_x);
               failed = 1'b1;
            end
            if (rsp_item.normal_y !== want.normal_y) begin
               $error("normal_y expected %0d actual %0d", want.normal_y, rsp_item.normal_y);
               failed = 1'b1;
            end
            if (rsp_item.normal_z !== want.normal_z) begin
               $error("normal_z expected %0d actual %0d", want.normal_z, rsp_item.normal_z);
               failed = 1'b1;
            end
            if (rsp_item.status !== want.status) begin
               $error("status expected %s actual %0d", want.status.name(), rsp_item.status);
               failed = 1'b1;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   typedef struct {
      req_type tri_in;
      bit      has_typed;
      rsp_type typed_normal;
   } directed_row_type;

   directed_row_type directed_rows[$];

   initial begin
      rsp_type zero_coincident, zero_collinear, up_z, none;
      int      idle_phases[4];
      failed      = 1'b0;
      cycle_count = 0;
      reset       = 1'b1;
      start       = 1'b0;
      req_item    = '0;
      none            = '0;
      zero_coincident = '{0, 0, 0, ST_COINCIDENT};
      zero_collinear  = '{0, 0, 0, ST_COLLINEAR};
      up_z            = '{0, 0, 16384, ST_VALID};

      // coincident: all three equal, each pair equal
      directed_rows.push_back('{'0, 1, zero_coincident});
      directed_rows.push_back('{{3{16'sh7fff, 16'sh8000, 16'sh0100}}, 1, zero_coincident});
      directed_rows.push_back('{{16'sd1, 16'sd2, 16'sd3, 16'sd1, 16'sd2, 16'sd3,
                                 16'sd9, 16'sd9, 16'sd9}, 1, zero_coincident});
      directed_rows.push_back('{{16'sd1, 16'sd2, 16'sd3, 16'sd9, 16'sd9, 16'sd9,
                                 16'sd1, 16'sd2, 16'sd3}, 1, zero_coincident});
      directed_rows.push_back('{{16'sd9, 16'sd9, 16'sd9, 16'sd1, 16'sd2, 16'sd3,
                                 16'sd1, 16'sd2, 16'sd3}, 1, zero_coincident});
      // collinear: distinct points on one line
      directed_rows.push_back('{{16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd256, 16'sd256,
                                 16'sd512, 16'sd512, 16'sd512}, 1, zero_collinear});
      directed_rows.push_back('{{16'sh8000, 16'sh8000, 16'sh8000, 16'sd0, 16'sd0, 16'sd0,
                                 16'sh7fff, 16'sh7fff, 16'sh7fff}, 0, none});
      // axis-aligned normals
      directed_rows.push_back('{{16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd0,
                                 16'sd256, 16'sd256, 16'sd0}, 1, up_z});
      directed_rows.push_back('{{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0,
                                 16'sd256, 16'sd256, 16'sd0}, 0, none});
      directed_rows.push_back('{{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0,
                                 16'sd0, 16'sd1, 16'sd1}, 0, none});
      // coordinate extremes
      directed_rows.push_back('{{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000,
                                 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000}, 0, none});
      directed_rows.push_back('{{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
                                 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000}, 0, none});
      directed_rows.push_back('{{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh7fff, 16'sh8000,
                                 16'sh7fff, 16'shffff, 16'sh0001, 16'sh8000}, 0, none});
      directed_rows.push_back('{{16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0,
                                 16'sd1, 16'sd1, 16'sd1}, 0, none});
      directed_rows.push_back('{{16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0,
                                 16'sd0, 16'sd0, 16'sd1}, 0, none});

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct = 0;
      foreach (directed_rows[i])
         send_triangle(directed_rows[i].tri_in, directed_rows[i].has_typed,
                       directed_rows[i].typed_normal);

      // random part, in phases of sender idling
      idle_phases = '{0, 74, 0, 29};
      foreach (idle_phases[ph]) begin
         sender_idle_pct = idle_phases[ph];
         repeat (210) send_triangle(make_triangle(), 1'b0, none);
      end
      start <= 1'b0;

      while (pending_normals.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!failed)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
`default_nettype wire

// ===== files.f =====
src/trinorm_pkg.sv
src/trinorm_front.sv
src/trinorm_div.sv
src/trinorm_isqrt.sv
src/triangle_unit_normal_unit.sv
verif/testbench.sv
